>>> rtl/lome_pkg.sv
// Package: shared types, constants and codes of the limit order matching engine.
`default_nettype none
package lome_pkg;
   localparam int BOOK_DEPTH = 32;
   localparam int MAX_USERS  = 16;
   localparam int BIDX_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
   localparam int BCNT_W = $clog2(BOOK_DEPTH + 1);
   localparam int UIDX_W = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
   localparam int UCNT_W = $clog2(MAX_USERS + 1);
   localparam int MAX_TRADES = 2 * BOOK_DEPTH - 1;
   localparam int TCNT_W = $clog2(MAX_TRADES + 1);
   localparam logic signed [47:0] BAL_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] BAL_MIN = 48'sh8000_0000_0000;
   localparam logic signed [39:0] SHR_MAX = 40'sh7F_FFFF_FFFF;
   localparam logic signed [39:0] SHR_MIN = 40'sh80_0000_0000;

   localparam logic [2:0] MODE_CREATE = 3'd0;
   localparam logic [2:0] MODE_BUY    = 3'd1;
   localparam logic [2:0] MODE_SELL   = 3'd2;
   localparam logic [2:0] MODE_RUN    = 3'd3;
   localparam logic [2:0] MODE_QUERY  = 3'd4;

   localparam logic [2:0] KIND_OK      = 3'd0;
   localparam logic [2:0] KIND_NO_USER = 3'd1;
   localparam logic [2:0] KIND_LOW_BAL = 3'd2;
   localparam logic [2:0] KIND_LOW_SHR = 3'd3;
   localparam logic [2:0] KIND_FULL    = 3'd4;
   localparam logic [2:0] KIND_TRADE   = 3'd5;
   localparam logic [2:0] KIND_DUP     = 3'd6;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] user_id;
      logic [15:0] price;
      logic [15:0] quantity;
      logic [31:0] start_balance;
      logic [23:0] start_shares;
   } req_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [15:0]        buyer_id;
      logic [15:0]        seller_id;
      logic [15:0]        trade_price;
      logic [15:0]        trade_qty;
      logic signed [47:0] user_balance;
      logic signed [39:0] user_shares;
      logic               last;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOOK, ST_DECIDE, ST_ACHK, ST_EMIT,
      ST_SCAN, ST_PICK, ST_FIND, ST_MUL, ST_UPD, ST_REMB, ST_REMS, ST_DONE
   } state_type;
endpackage
`default_nettype wire

>>> rtl/lome_if.sv
// Interfaces: valid/ready channels for requests and responses.
`default_nettype none
interface lome_req_if;
   import lome_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface lome_rsp_if;
   import lome_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/limit_order_matching_engine_top.sv
// Top level: limit order matching engine with request queue and executor.
//  channel | dir | payload
//  req_    | in  | mode, user_id, price, quantity, start_balance, start_shares
//  rsp_    | out | kind, ids, trade_price, trade_qty, balance, shares, last
// Account lookup walks the table one entry a cycle for create, order entry
// and query. A match run scans both books for the best bid and ask before
// each trade. Synchronous active-high reset empties the books and table.
// A stalled response holds the executor; the front queue keeps taking
// requests until it holds two.
`default_nettype none
module limit_order_matching_engine_top
   import lome_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   lome_req_if.sink   req,
   lome_rsp_if.source rsp
);
   logic    q_valid, q_ready;
   req_type q_data;

   lome_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   lome_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );

   // a trade transfer never carries last
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.kind == KIND_TRADE |-> !rsp.data.last)
      else $error("trade marked last");
   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("response dropped");
   // queue hands off only to an idle executor
   assert property (@(posedge clock) disable iff (reset)
      q_valid && q_ready |=> !q_ready)
      else $error("executor took two requests");
endmodule
`default_nettype wire

>>> rtl/lome_front.sv
// Front end: two-entry request queue that decouples intake from execution.
`default_nettype none
module lome_front
   import lome_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire req_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output req_type      out_data
);
   req_type    q_ff [2];
   req_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop, keep;

   // drop unused modes at intake, they cause no response
   assign keep     = (in_data.mode <= MODE_QUERY);
   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready && keep;
   assign pop      = out_valid && out_ready;
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = q_ff[0];

   always_comb begin
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         if (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)) q_in[0] = in_data;
         else q_in[1] = in_data;
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end
endmodule
`default_nettype wire

>>> rtl/lome_back.sv
// Back end: account table, order books and the matching sequencer.
`default_nettype none
module lome_back
   import lome_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire req_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);
   state_type state_ff, state_in;
   req_type   cur_ff;
   rsp_type   rsp_ff;
   logic      rv_ff;

   logic [15:0]        acc_id  [MAX_USERS];
   logic signed [47:0] acc_bal [MAX_USERS];
   logic signed [39:0] acc_shr [MAX_USERS];
   logic [UCNT_W-1:0]  acc_cnt_ff;

   logic [15:0] bp [BOOK_DEPTH]; logic [15:0] bq [BOOK_DEPTH];
   logic [15:0] bo [BOOK_DEPTH]; logic [31:0] ba [BOOK_DEPTH];
   logic [15:0] sp [BOOK_DEPTH]; logic [15:0] sq [BOOK_DEPTH];
   logic [15:0] so [BOOK_DEPTH]; logic [31:0] sa [BOOK_DEPTH];
   logic [BCNT_W-1:0] bcnt_ff, scnt_ff;
   logic [31:0]       seq_ff;

   // walk counters and match registers
   logic [UCNT_W-1:0] ui_ff;
   logic [UIDX_W-1:0] hit_ff, hb_ff;
   logic              found_ff, fb_ff, fs_ff;
   logic [BCNT_W-1:0] si_ff;
   logic [BIDX_W-1:0] bb_ff, bs_ff;
   logic [TCNT_W-1:0] nt_ff;
   logic [15:0]       tq_ff;
   logic [31:0]       val_ff;
   logic signed [48:0] need_ff;
   logic [15:0]       look_id_ff;
   logic              pass_ff;

   logic out_free;
   assign out_free  = !rv_ff || out_ready;
   assign out_valid = rv_ff;
   assign out_data  = rsp_ff;
   assign in_ready  = (state_ff == ST_IDLE);

   function automatic logic bolder(input logic [31:0] a, input logic [31:0] b,
                                   input logic [31:0] s);
      return (s - a) > (s - b);
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (in_valid) state_in = (in_data.mode == MODE_RUN) ? ST_PICK : ST_LOOK;
         ST_LOOK:   if (ui_ff >= acc_cnt_ff || found_ff) state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_ACHK;
         ST_ACHK:   if (out_free) state_in = ST_EMIT;
         ST_EMIT:   if (out_free) state_in = ST_IDLE;
         ST_PICK:   state_in = (bcnt_ff == '0 || scnt_ff == '0 ||
                                nt_ff >= TCNT_W'(MAX_TRADES)) ? ST_DONE : ST_SCAN;
         ST_SCAN:   if (si_ff >= BCNT_W'(BOOK_DEPTH)) state_in =
                       (bp[bb_ff] < sp[bs_ff]) ? ST_DONE : ST_FIND;
         ST_FIND:   if (ui_ff >= acc_cnt_ff) state_in = (fb_ff && fs_ff) ? ST_MUL : ST_REMB;
         ST_MUL:    state_in = ST_UPD;
         ST_UPD:    if (out_free) state_in = ST_REMB;
         ST_REMB:   state_in = ST_REMS;
         ST_REMS:   state_in = ST_PICK;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   logic [15:0] rem_b, rem_s;
   logic signed [47:0] nb_b, nb_s, nb_x;
   logic signed [39:0] ns_b, ns_s, ns_x;
   logic signed [49:0] tb_b, tb_s, tb_x;
   logic signed [41:0] tt_b, tt_s, tt_x;
   logic [15:0] tq_c;
   always_comb begin
      tq_c = (bq[bb_ff] < sq[bs_ff]) ? bq[bb_ff] : sq[bs_ff];
      tb_b = 50'(acc_bal[hb_ff]) - $signed({18'd0, val_ff});
      tb_s = 50'(acc_bal[hit_ff]) + $signed({18'd0, val_ff});
      tt_b = 42'(acc_shr[hb_ff]) + $signed({26'd0, tq_ff});
      tt_s = 42'(acc_shr[hit_ff]) - $signed({26'd0, tq_ff});
      nb_b = (tb_b > 50'(BAL_MAX)) ? BAL_MAX : (tb_b < 50'(BAL_MIN)) ? BAL_MIN : tb_b[47:0];
      nb_s = (tb_s > 50'(BAL_MAX)) ? BAL_MAX : (tb_s < 50'(BAL_MIN)) ? BAL_MIN : tb_s[47:0];
      ns_b = (tt_b > 42'(SHR_MAX)) ? SHR_MAX : (tt_b < 42'(SHR_MIN)) ? SHR_MIN : tt_b[39:0];
      ns_s = (tt_s > 42'(SHR_MAX)) ? SHR_MAX : (tt_s < 42'(SHR_MIN)) ? SHR_MIN : tt_s[39:0];
      // self trade: seller side applies on top of the saturated buyer side
      tb_x = 50'(nb_b) + $signed({18'd0, val_ff});
      tt_x = 42'(ns_b) - $signed({26'd0, tq_ff});
      nb_x = (tb_x > 50'(BAL_MAX)) ? BAL_MAX : (tb_x < 50'(BAL_MIN)) ? BAL_MIN : tb_x[47:0];
      ns_x = (tt_x > 42'(SHR_MAX)) ? SHR_MAX : (tt_x < 42'(SHR_MIN)) ? SHR_MIN : tt_x[39:0];
      rem_b = bq[bb_ff] - tq_ff;
      rem_s = sq[bs_ff] - tq_ff;
   end

   logic [BIDX_W-1:0] sidx;
   assign sidx = si_ff[BIDX_W-1:0];

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rv_ff <= 1'b0;
         acc_cnt_ff <= '0; bcnt_ff <= '0; scnt_ff <= '0; seq_ff <= 32'd1;
      end else begin
         state_ff <= state_in;
         if (rv_ff && out_ready) rv_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (in_valid) begin
               cur_ff <= in_data; ui_ff <= '0; found_ff <= 1'b0; nt_ff <= '0;
               look_id_ff <= in_data.user_id;
               need_ff <= $signed({17'd0, 32'(in_data.price * in_data.quantity)});
            end
            ST_LOOK: if (!(ui_ff >= acc_cnt_ff || found_ff)) begin
               if (acc_id[ui_ff[UIDX_W-1:0]] == look_id_ff) begin
                  found_ff <= 1'b1; hit_ff <= ui_ff[UIDX_W-1:0];
               end
               ui_ff <= ui_ff + 1'b1;
            end
            ST_DECIDE: begin
               pass_ff <= 1'b0;
               case (cur_ff.mode)
                  MODE_BUY:  pass_ff <= found_ff && (49'(acc_bal[hit_ff]) >= need_ff);
                  MODE_SELL: pass_ff <= found_ff &&
                                (41'(acc_shr[hit_ff]) >= $signed({25'd0, cur_ff.quantity}));
                  default:   pass_ff <= 1'b0;
               endcase
            end
            // hold until the response register is free
            ST_ACHK: if (out_free) begin
               rsp_ff <= '0; rsp_ff.last <= 1'b1;
               case (cur_ff.mode)
                  MODE_CREATE:
                     if (found_ff) rsp_ff.kind <= KIND_DUP;
                     else if (acc_cnt_ff >= UCNT_W'(MAX_USERS)) rsp_ff.kind <= KIND_FULL;
                     else begin
                        rsp_ff.kind <= KIND_OK;
                        acc_id[acc_cnt_ff[UIDX_W-1:0]]  <= cur_ff.user_id;
                        acc_bal[acc_cnt_ff[UIDX_W-1:0]] <= $signed({16'd0, cur_ff.start_balance});
                        acc_shr[acc_cnt_ff[UIDX_W-1:0]] <= $signed({16'd0, cur_ff.start_shares});
                        acc_cnt_ff <= acc_cnt_ff + 1'b1;
                     end
                  MODE_BUY:
                     if (!found_ff) rsp_ff.kind <= KIND_NO_USER;
                     else if (!pass_ff) rsp_ff.kind <= KIND_LOW_BAL;
                     else if (bcnt_ff >= BCNT_W'(BOOK_DEPTH)) rsp_ff.kind <= KIND_FULL;
                     else begin
                        rsp_ff.kind <= KIND_OK;
                        bp[bcnt_ff[BIDX_W-1:0]] <= cur_ff.price;
                        bq[bcnt_ff[BIDX_W-1:0]] <= cur_ff.quantity;
                        bo[bcnt_ff[BIDX_W-1:0]] <= cur_ff.user_id;
                        ba[bcnt_ff[BIDX_W-1:0]] <= seq_ff;
                        bcnt_ff <= bcnt_ff + 1'b1; seq_ff <= seq_ff + 32'd1;
                     end
                  MODE_SELL:
                     if (!found_ff) rsp_ff.kind <= KIND_NO_USER;
                     else if (!pass_ff) rsp_ff.kind <= KIND_LOW_SHR;
                     else if (scnt_ff >= BCNT_W'(BOOK_DEPTH)) rsp_ff.kind <= KIND_FULL;
                     else begin
                        rsp_ff.kind <= KIND_OK;
                        sp[scnt_ff[BIDX_W-1:0]] <= cur_ff.price;
                        sq[scnt_ff[BIDX_W-1:0]] <= cur_ff.quantity;
                        so[scnt_ff[BIDX_W-1:0]] <= cur_ff.user_id;
                        sa[scnt_ff[BIDX_W-1:0]] <= seq_ff;
                        scnt_ff <= scnt_ff + 1'b1; seq_ff <= seq_ff + 32'd1;
                     end
                  default:
                     if (!found_ff) rsp_ff.kind <= KIND_NO_USER;
                     else begin
                        rsp_ff.kind <= KIND_OK;
                        rsp_ff.user_balance <= acc_bal[hit_ff];
                        rsp_ff.user_shares  <= acc_shr[hit_ff];
                     end
               endcase
            end
            ST_EMIT: if (out_free) rv_ff <= 1'b1;
            ST_PICK: begin
               si_ff <= BCNT_W'(1); bb_ff <= '0; bs_ff <= '0;
            end
            ST_SCAN: if (si_ff < BCNT_W'(BOOK_DEPTH)) begin
               // advance one slot of each book per cycle
               if (si_ff < bcnt_ff && (bp[sidx] > bp[bb_ff] || (bp[sidx] == bp[bb_ff] &&
                   bolder(ba[sidx], ba[bb_ff], seq_ff)))) bb_ff <= sidx;
               if (si_ff < scnt_ff && (sp[sidx] < sp[bs_ff] || (sp[sidx] == sp[bs_ff] &&
                   bolder(sa[sidx], sa[bs_ff], seq_ff)))) bs_ff <= sidx;
               si_ff <= si_ff + 1'b1;
               ui_ff <= '0; fb_ff <= 1'b0; fs_ff <= 1'b0;
            end
            ST_FIND: if (ui_ff < acc_cnt_ff) begin
               if (!fb_ff && acc_id[ui_ff[UIDX_W-1:0]] == bo[bb_ff]) begin
                  fb_ff <= 1'b1; hb_ff <= ui_ff[UIDX_W-1:0];
               end
               if (!fs_ff && acc_id[ui_ff[UIDX_W-1:0]] == so[bs_ff]) begin
                  fs_ff <= 1'b1; hit_ff <= ui_ff[UIDX_W-1:0];
               end
               ui_ff <= ui_ff + 1'b1;
            end else if (!(fb_ff && fs_ff)) begin
               tq_ff <= bq[bb_ff]; // drop both orders whole
            end
            ST_MUL: begin
               tq_ff  <= tq_c;
               val_ff <= tq_c * sp[bs_ff];
            end
            ST_UPD: if (out_free) begin
               acc_bal[hb_ff] <= nb_b; acc_shr[hb_ff] <= ns_b;
               if (hit_ff == hb_ff) begin
                  acc_bal[hit_ff] <= nb_x; acc_shr[hit_ff] <= ns_x;
               end else begin
                  acc_bal[hit_ff] <= nb_s; acc_shr[hit_ff] <= ns_s;
               end
               rsp_ff <= '0;
               rsp_ff.kind <= KIND_TRADE; rsp_ff.buyer_id <= bo[bb_ff];
               rsp_ff.seller_id <= so[bs_ff]; rsp_ff.trade_price <= sp[bs_ff];
               rsp_ff.trade_qty <= tq_ff;
               rv_ff <= 1'b1; nt_ff <= nt_ff + 1'b1;
            end
            ST_REMB: begin
               if (!(fb_ff && fs_ff) || rem_b == 16'd0) begin
                  bp[bb_ff] <= bp[bcnt_ff[BIDX_W-1:0] - 1'b1];
                  bq[bb_ff] <= bq[bcnt_ff[BIDX_W-1:0] - 1'b1];
                  bo[bb_ff] <= bo[bcnt_ff[BIDX_W-1:0] - 1'b1];
                  ba[bb_ff] <= ba[bcnt_ff[BIDX_W-1:0] - 1'b1];
                  bcnt_ff <= bcnt_ff - 1'b1;
               end else bq[bb_ff] <= rem_b;
            end
            ST_REMS: begin
               if (!(fb_ff && fs_ff) || rem_s == 16'd0) begin
                  sp[bs_ff] <= sp[scnt_ff[BIDX_W-1:0] - 1'b1];
                  sq[bs_ff] <= sq[scnt_ff[BIDX_W-1:0] - 1'b1];
                  so[bs_ff] <= so[scnt_ff[BIDX_W-1:0] - 1'b1];
                  sa[bs_ff] <= sa[scnt_ff[BIDX_W-1:0] - 1'b1];
                  scnt_ff <= scnt_ff - 1'b1;
               end else sq[bs_ff] <= rem_s;
            end
            ST_DONE: if (out_free) begin
               rsp_ff <= '0; rsp_ff.kind <= KIND_OK; rsp_ff.last <= 1'b1; rv_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire
